// ===== sv/wfs_pkg.sv =====
package wfs_pkg;

    // item modes
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_ENQ   = 2'd0;
    localparam t_mode MODE_TICK  = 2'd1;
    localparam t_mode MODE_CLEAR = 2'd2;
    localparam t_mode MODE_PLACE = 2'd3;

    // configuration registers
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_WALK_SPEED = 1'b0;
    localparam t_cfg_idx REG_ARRIVE_TOL = 1'b1;
    localparam logic [CFG_W-1:0] WALK_SPEED_RST = 16'd896;
    localparam logic [CFG_W-1:0] ARRIVE_TOL_RST = 16'd1280;

    // arithmetic widths
    localparam int TICK_W  = 10;
    localparam int SCALE_W = CFG_W + TICK_W;
    localparam int RAD_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int ROOT_CNT_W = 5;
    localparam int SQ_IN_W = 31;
    localparam int SH_W    = 2;

endpackage

// ===== sv/wfs_wpt_mem.sv =====
module wfs_wpt_mem #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/wfs_isqrt.sv =====
module wfs_isqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [wfs_pkg::RAD_W-1:0] i_rad,
    output logic                      o_done,
    output logic [wfs_pkg::ROOT_W-1:0] o_root
);

    localparam int REM_W = wfs_pkg::ROOT_W + 2;

    logic [wfs_pkg::RAD_W-1:0]      r_rad;
    logic [REM_W-1:0]               r_rem;
    logic [wfs_pkg::ROOT_W-1:0]     r_root;
    logic [wfs_pkg::ROOT_CNT_W-1:0] r_cnt;
    logic                           r_run;
    logic                           r_done;

    logic [REM_W+1:0] t_rem;
    logic [REM_W+1:0] t_trial;
    logic             ge;
    logic [REM_W+1:0] t_diff;
    logic [REM_W-1:0] n_rem;

    // one root bit per cycle: bring down two radicand bits, try 4r+1
    always_comb begin
        t_rem   = {r_rem, r_rad[wfs_pkg::RAD_W-1 -: 2]};
        t_trial = {2'b00, r_root, 2'b01};
        ge      = t_rem >= t_trial;
        t_diff  = t_rem - t_trial;
        n_rem   = ge ? t_diff[REM_W-1:0] : t_rem[REM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rad  <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
                r_run  <= 1'b1;
            end else if (r_run) begin
                r_rad  <= {r_rad[wfs_pkg::RAD_W-3:0], 2'b00};
                r_rem  <= n_rem;
                r_root <= {r_root[wfs_pkg::ROOT_W-2:0], ge};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == wfs_pkg::ROOT_CNT_W'(wfs_pkg::ROOT_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== sv/wfs_div.sv =====
module wfs_div #(
    parameter int NUM_W = 59,
    parameter int DEN_W = 38
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quot;
    logic [CNT_W-1:0] r_cnt;
    logic             r_run;
    logic             r_done;

    logic [DEN_W:0] t_rem;
    logic [DEN_W:0] t_diff;
    logic           ge;
    logic [DEN_W-1:0] n_rem;

    // restoring division, one quotient bit per cycle
    always_comb begin
        t_rem  = {r_rem, r_num[NUM_W-1]};
        ge     = t_rem >= {1'b0, r_den};
        t_diff = t_rem - {1'b0, r_den};
        n_rem  = ge ? t_diff[DEN_W-1:0] : t_rem[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quot <= '0;
                r_cnt  <= '0;
                r_run  <= 1'b1;
            end else if (r_run) begin
                r_num  <= {r_num[NUM_W-2:0], 1'b0};
                r_rem  <= n_rem;
                r_quot <= {r_quot[NUM_W-2:0], ge};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== sv/waypoint_follower_stepper.sv =====
// timing: enqueue, clear, place and a tick on an empty queue give their result
// in the cycle after the transaction; a tick that pops a waypoint answers from S_CHK;
// a moving tick walks S_CHK, S_MUL, S_SUM, S_SQ, S_DVS, S_DIV and S_UPD, waiting in S_SQ
// on the bit-serial square root and in S_DIV on the bit-serial step divide
// throughput: one item at a time, busy stays high until the result strobe
// reset: synchronous active low, position, step and queue cleared; receiver cannot stall
module waypoint_follower_stepper #(
    parameter int QUEUE_DEPTH = 16,
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_mode,
    input  logic signed [COORD_WIDTH-1:0] i_target_x,
    input  logic signed [COORD_WIDTH-1:0] i_target_y,
    input  logic [wfs_pkg::TICK_W-1:0]    i_tick_ms,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [wfs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wfs_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                          o_done,
    output logic signed [COORD_WIDTH-1:0] o_pos_x,
    output logic signed [COORD_WIDTH-1:0] o_pos_y,
    output logic signed [COORD_WIDTH-1:0] o_vel_x,
    output logic signed [COORD_WIDTH-1:0] o_vel_y,
    output logic                          o_moving,
    output logic                          o_arrived,
    output logic                          o_dropped
);

    localparam int CW     = COORD_WIDTH;
    localparam int QW     = $clog2(QUEUE_DEPTH);
    localparam int CNTW   = $clog2(QUEUE_DEPTH + 1);
    localparam int AW     = CW + 1;
    localparam int MAXS   = (AW > 31) ? (AW - 31) : 0;
    localparam int DIST_W = wfs_pkg::ROOT_W + wfs_pkg::SH_W;
    localparam int DVS_W  = DIST_W + 4;
    localparam int PR_W   = wfs_pkg::SCALE_W + AW;
    localparam int SQ_W   = 2 * wfs_pkg::SQ_IN_W;

    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_SQ   = 3'd4;
    localparam logic [2:0] S_DVS  = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_UPD  = 3'd7;

    logic [2:0]                   r_state;
    logic [wfs_pkg::CFG_W-1:0]    r_ws;
    logic [wfs_pkg::CFG_W-1:0]    r_tol;
    logic [CW-1:0]                r_pos_x, r_pos_y;
    logic [CW-1:0]                r_stp_x, r_stp_y;
    logic [QW-1:0]                r_head;
    logic [CNTW-1:0]              r_count;
    logic                         r_done, r_arrived, r_dropped;
    logic [wfs_pkg::TICK_W-1:0]   r_dt;
    logic                         r_neg_x, r_neg_y;
    logic [AW-1:0]                r_ax, r_ay;
    logic [wfs_pkg::SH_W-1:0]     r_sh;
    logic [wfs_pkg::SQ_IN_W-1:0]  r_sx, r_sy;
    logic [wfs_pkg::SCALE_W-1:0]  r_scale;
    logic [SQ_W-1:0]              r_sqx, r_sqy;
    logic [PR_W-1:0]              r_prx, r_pry;
    logic [DVS_W-1:0]             r_dvs;

    logic                         accept;
    logic                         cfg_we;
    logic [QW:0]                  slot_sum;
    logic [QW-1:0]                n_slot;
    logic [QW-1:0]                n_head;
    logic                         queue_full;
    logic                         mem_we, mem_re;
    logic [2*CW-1:0]              mem_rdata;
    logic [AW-1:0]                dx, dy, ax, ay, orv;
    logic                         near;
    logic [wfs_pkg::SH_W-1:0]     n_sh;
    logic [63:0]                  shx, shy;
    logic                         sq_start, sq_done;
    logic [wfs_pkg::ROOT_W-1:0]   root;
    logic [DIST_W-1:0]            span, span_nz;
    logic [DVS_W-1:0]             n_dvs;
    logic                         div_start, div_done_x, div_done_y;
    logic [PR_W-1:0]              quot_x, quot_y;
    logic [CW-1:0]                mag_x, mag_y;
    logic [CW:0]                  sum_x, sum_y;
    logic [CW-1:0]                n_pos_x, n_pos_y;

    assign accept      = start && !busy;
    assign busy        = r_state != S_IDLE;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // queue slot arithmetic
    always_comb begin
        slot_sum   = {1'b0, r_head} + (QW+1)'(r_count);
        n_slot     = (slot_sum >= (QW+1)'(QUEUE_DEPTH)) ?
                     QW'(slot_sum - (QW+1)'(QUEUE_DEPTH)) : QW'(slot_sum);
        n_head     = (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
        queue_full = r_count == CNTW'(QUEUE_DEPTH);
    end

    assign mem_we = accept && (i_mode == wfs_pkg::MODE_ENQ) && !queue_full;
    assign mem_re = accept && (i_mode == wfs_pkg::MODE_TICK) && (r_count != '0);

    wfs_wpt_mem #(
        .DEPTH  (QUEUE_DEPTH),
        .DATA_W (2 * CW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (n_slot),
        .i_wdata ({i_target_x, i_target_y}),
        .i_re    (mem_re),
        .i_raddr (r_head),
        .o_rdata (mem_rdata)
    );

    // offset to front waypoint, tolerance box and pre-shift
    always_comb begin
        dx   = {mem_rdata[2*CW-1], mem_rdata[2*CW-1:CW]} - {r_pos_x[CW-1], r_pos_x};
        dy   = {mem_rdata[CW-1], mem_rdata[CW-1:0]} - {r_pos_y[CW-1], r_pos_y};
        ax   = dx[AW-1] ? -dx : dx;
        ay   = dy[AW-1] ? -dy : dy;
        near = (ax <= AW'(r_tol)) && (ay <= AW'(r_tol));
        orv  = ax | ay;
        n_sh = '0;
        for (int i = MAXS; i >= 0; i--) begin
            if ((64'(orv) >> i) < 64'h8000_0000) begin
                n_sh = wfs_pkg::SH_W'(i);
            end
        end
        shx = 64'(ax) >> n_sh;
        shy = 64'(ay) >> n_sh;
    end

    assign sq_start = r_state == S_SUM;

    wfs_isqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (wfs_pkg::RAD_W'(r_sqx) + wfs_pkg::RAD_W'(r_sqy)),
        .o_done  (sq_done),
        .o_root  (root)
    );

    // distance back to scale, then ten times it as the divisor
    always_comb begin
        span    = DIST_W'(root) << r_sh;
        span_nz = (span == '0) ? DIST_W'(1) : span;
        n_dvs   = (DVS_W'(span_nz) << 3) + (DVS_W'(span_nz) << 1);
    end

    assign div_start = r_state == S_DVS;

    wfs_div #(.NUM_W(PR_W), .DEN_W(DVS_W)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_prx),
        .i_den   (r_dvs),
        .o_done  (div_done_x),
        .o_quot  (quot_x)
    );

    wfs_div #(.NUM_W(PR_W), .DEN_W(DVS_W)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_pry),
        .i_den   (r_dvs),
        .o_done  (div_done_y),
        .o_quot  (quot_y)
    );

    // saturated step magnitudes and the new position
    always_comb begin
        mag_x   = (quot_x > PR_W'(CMAX)) ? CMAX : quot_x[CW-1:0];
        mag_y   = (quot_y > PR_W'(CMAX)) ? CMAX : quot_y[CW-1:0];
        sum_x   = {r_pos_x[CW-1], r_pos_x} + {r_stp_x[CW-1], r_stp_x};
        sum_y   = {r_pos_y[CW-1], r_pos_y} + {r_stp_y[CW-1], r_stp_y};
        n_pos_x = (sum_x[CW] != sum_x[CW-1]) ? (sum_x[CW] ? CMIN : CMAX) : sum_x[CW-1:0];
        n_pos_y = (sum_y[CW] != sum_y[CW-1]) ? (sum_y[CW] ? CMIN : CMAX) : sum_y[CW-1:0];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws  <= wfs_pkg::WALK_SPEED_RST;
            r_tol <= wfs_pkg::ARRIVE_TOL_RST;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                wfs_pkg::REG_WALK_SPEED: r_ws  <= i_cfg_data;
                wfs_pkg::REG_ARRIVE_TOL: r_tol <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // datapath registers of a moving tick
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dt <= i_tick_ms;
        end
        if (r_state == S_CHK) begin
            r_neg_x <= dx[AW-1];
            r_neg_y <= dy[AW-1];
            r_ax    <= ax;
            r_ay    <= ay;
            r_sh    <= n_sh;
            r_sx    <= shx[wfs_pkg::SQ_IN_W-1:0];
            r_sy    <= shy[wfs_pkg::SQ_IN_W-1:0];
            r_scale <= wfs_pkg::SCALE_W'(r_ws) * wfs_pkg::SCALE_W'(r_dt);
        end
        if (r_state == S_MUL) begin
            r_sqx <= SQ_W'(r_sx) * SQ_W'(r_sx);
            r_sqy <= SQ_W'(r_sy) * SQ_W'(r_sy);
            r_prx <= PR_W'(r_scale) * PR_W'(r_ax);
            r_pry <= PR_W'(r_scale) * PR_W'(r_ay);
        end
        if (r_state == S_SQ && sq_done) begin
            r_dvs <= n_dvs;
        end
    end

    // sequencer and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_stp_x   <= '0;
            r_stp_y   <= '0;
            r_head    <= '0;
            r_count   <= '0;
            r_done    <= 1'b0;
            r_arrived <= 1'b0;
            r_dropped <= 1'b0;
        end else begin
            r_done    <= 1'b0;
            r_arrived <= 1'b0;
            r_dropped <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_mode)
                            wfs_pkg::MODE_ENQ: begin
                                r_done <= 1'b1;
                                if (queue_full) begin
                                    r_dropped <= 1'b1;
                                end else begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            wfs_pkg::MODE_TICK: begin
                                if (r_count == '0) begin
                                    r_done <= 1'b1;
                                end else begin
                                    r_state <= S_CHK;
                                end
                            end
                            wfs_pkg::MODE_CLEAR: begin
                                r_head  <= '0;
                                r_count <= '0;
                                r_done  <= 1'b1;
                            end
                            wfs_pkg::MODE_PLACE: begin
                                r_pos_x <= i_target_x;
                                r_pos_y <= i_target_y;
                                r_stp_x <= '0;
                                r_stp_y <= '0;
                                r_done  <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_CHK: begin
                    if (near) begin
                        r_head    <= n_head;
                        r_count   <= r_count - 1'b1;
                        r_stp_x   <= '0;
                        r_stp_y   <= '0;
                        r_arrived <= 1'b1;
                        r_done    <= 1'b1;
                        r_state   <= S_IDLE;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_SUM;
                S_SUM: r_state <= S_SQ;
                S_SQ: begin
                    if (sq_done) begin
                        r_state <= S_DVS;
                    end
                end
                S_DVS: r_state <= S_DIV;
                S_DIV: begin
                    if (div_done_x) begin
                        r_stp_x <= r_neg_x ? -mag_x : mag_x;
                        r_stp_y <= r_neg_y ? -mag_y : mag_y;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_pos_x <= n_pos_x;
                    r_pos_y <= n_pos_y;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done    = r_done;
    assign o_pos_x   = r_pos_x;
    assign o_pos_y   = r_pos_y;
    assign o_vel_x   = r_stp_x;
    assign o_vel_y   = r_stp_y;
    assign o_moving  = r_count != '0;
    assign o_arrived = r_arrived;
    assign o_dropped = r_dropped;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_arrive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_arrived |-> (o_done && o_vel_x == '0 && o_vel_y == '0))
        else $error("arrival without zeroed step");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dropped |-> (o_done && r_count == CNTW'(QUEUE_DEPTH)))
        else $error("drop with room in queue");

    a_empty_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_mode == wfs_pkg::MODE_TICK && r_count == '0) |=> (o_done && !busy))
        else $error("empty tick not answered at once");

    a_div_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done_x == div_done_y)
        else $error("step dividers out of step");
`endif

endmodule

// ===== sim/waypoint_follower_stepper_tb.sv =====
`timescale 1ns / 1ps

module waypoint_follower_stepper_tb;

    localparam int CW      = 24;
    localparam int QDEPTH  = 16;
    localparam int N_RAND  = 1550;
    localparam int WD_MAX  = 4000;
    localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint CMIN = -CMAX - 1;

    typedef struct packed {
        logic [CW-1:0] pos_x;
        logic [CW-1:0] pos_y;
        logic [CW-1:0] vel_x;
        logic [CW-1:0] vel_y;
        logic          moving;
        logic          arrived;
        logic          dropped;
    } t_motion;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic [1:0]                     i_mode;
    logic signed [CW-1:0]           i_target_x;
    logic signed [CW-1:0]           i_target_y;
    logic [wfs_pkg::TICK_W-1:0]     i_tick_ms;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [wfs_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [wfs_pkg::CFG_W-1:0]      i_cfg_data;
    logic                           o_done;
    logic signed [CW-1:0]           o_pos_x, o_pos_y, o_vel_x, o_vel_y;
    logic                           o_moving, o_arrived, o_dropped;

    waypoint_follower_stepper dut (.*);

    // clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // follower model state
    longint    pos_x_m, pos_y_m, vel_x_m, vel_y_m;
    longint    wp_x [QDEPTH];
    longint    wp_y [QDEPTH];
    int        q_head, q_count;
    longint    speed_m, tol_m;
    t_motion   expected_motion [$];
    int        n_errors;
    int        idle_cycles;

    function automatic longint clamp_coord(longint v);
        if (v > CMAX) return CMAX;
        if (v < CMIN) return CMIN;
        return v;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned root, bit_w;
        root  = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (v >= root + bit_w) begin
                v    = v - (root + bit_w);
                root = (root >> 1) + bit_w;
            end else begin
                root = root >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return root;
    endfunction

    function automatic longint step_part(longint d, longint unsigned num,
                                         longint unsigned span);
        longint unsigned ad, m;
        ad = (d < 0) ? -d : d;
        m  = (num * ad) / (10 * span);
        if (m > CMAX) m = CMAX;
        return (d < 0) ? -longint'(m) : longint'(m);
    endfunction

    // predict the motion after one item
    function automatic t_motion predict_motion(wfs_pkg::t_mode mode, longint tx, longint ty,
                                               int tick);
        t_motion r;
        longint  dx, dy, ax, ay;
        longint unsigned span;
        int      slot;
        r = '0;
        case (mode)
            wfs_pkg::MODE_ENQ: begin
                if (q_count >= QDEPTH) begin
                    r.dropped = 1'b1;
                end else begin
                    slot = (q_head + q_count) % QDEPTH;
                    wp_x[slot] = tx;
                    wp_y[slot] = ty;
                    q_count++;
                end
            end
            wfs_pkg::MODE_TICK: begin
                if (q_count != 0) begin
                    dx = wp_x[q_head] - pos_x_m;
                    dy = wp_y[q_head] - pos_y_m;
                    ax = (dx < 0) ? -dx : dx;
                    ay = (dy < 0) ? -dy : dy;
                    if (ax <= tol_m && ay <= tol_m) begin
                        q_head  = (q_head + 1) % QDEPTH;
                        q_count--;
                        vel_x_m = 0;
                        vel_y_m = 0;
                        r.arrived = 1'b1;
                    end else begin
                        span = int_sqrt(ax * ax + ay * ay);
                        if (span == 0) span = 1;
                        vel_x_m = step_part(dx, speed_m * tick, span);
                        vel_y_m = step_part(dy, speed_m * tick, span);
                        pos_x_m = clamp_coord(pos_x_m + vel_x_m);
                        pos_y_m = clamp_coord(pos_y_m + vel_y_m);
                    end
                end
            end
            wfs_pkg::MODE_CLEAR: begin
                q_head  = 0;
                q_count = 0;
            end
            default: begin
                pos_x_m = tx;
                pos_y_m = ty;
                vel_x_m = 0;
                vel_y_m = 0;
            end
        endcase
        r.pos_x  = pos_x_m[CW-1:0];
        r.pos_y  = pos_y_m[CW-1:0];
        r.vel_x  = vel_x_m[CW-1:0];
        r.vel_y  = vel_y_m[CW-1:0];
        r.moving = (q_count != 0);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // send one item, predicting on the accepting edge
    task automatic send_item(wfs_pkg::t_mode mode, longint tx, longint ty, int tick);
        i_mode     = mode;
        i_target_x = tx[CW-1:0];
        i_target_y = ty[CW-1:0];
        i_tick_ms  = tick[wfs_pkg::TICK_W-1:0];
        start      = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_motion.push_back(predict_motion(mode, tx, ty, tick));
        @(negedge i_clk);
        start = 1'b0;
    endtask

    // burst-shaped gaps between items
    int burst_left;
    task automatic sender_gap();
        if (burst_left == 0) begin
            burst_left = $urandom_range(0, 20);
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_drained();
        while (expected_motion.size() != 0) @(negedge i_clk);
        repeat (5) @(negedge i_clk);
    endtask

    task automatic write_reg(wfs_pkg::t_cfg_idx idx, logic [wfs_pkg::CFG_W-1:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == wfs_pkg::REG_WALK_SPEED) speed_m = val;
        else tol_m = val;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic longint rand_coord();
        longint v;
        case ($urandom_range(0, 3))
            0: v = $signed(24'($urandom));
            1: v = longint'($urandom_range(0, 20000)) - 10000;
            2: v = ($urandom_range(0, 1)) ? CMAX - $urandom_range(0, 3000)
                                          : CMIN + $urandom_range(0, 3000);
            default: v = longint'($urandom_range(0, 400000)) - 200000;
        endcase
        return v;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_motion want;
        if (i_rst_n && o_done) begin
            if (expected_motion.size() == 0) begin
                $display("unexpected result at %0t", $realtime);
                n_errors++;
            end else begin
                want = expected_motion.pop_front();
                if (o_pos_x !== want.pos_x) report_mismatch("pos_x", o_pos_x, want.pos_x);
                if (o_pos_y !== want.pos_y) report_mismatch("pos_y", o_pos_y, want.pos_y);
                if (o_vel_x !== want.vel_x) report_mismatch("vel_x", o_vel_x, want.vel_x);
                if (o_vel_y !== want.vel_y) report_mismatch("vel_y", o_vel_y, want.vel_y);
                if (o_moving !== want.moving)
                    report_mismatch("moving", o_moving, want.moving);
                if (o_arrived !== want.arrived)
                    report_mismatch("arrived", o_arrived, want.arrived);
                if (o_dropped !== want.dropped)
                    report_mismatch("dropped", o_dropped, want.dropped);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (o_done || (start && !busy) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_MAX) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_directed();
        // placement extremes and back to origin
        send_item(wfs_pkg::MODE_PLACE, CMAX, CMIN, 0);
        send_item(wfs_pkg::MODE_PLACE, CMIN, CMAX, 1023);
        send_item(wfs_pkg::MODE_PLACE, 0, 0, 0);
        // tick on an empty queue
        send_item(wfs_pkg::MODE_TICK, -1, -1, 1023);
        // nearby waypoint: zero tick, move, overshoot on a long tick, step back
        send_item(wfs_pkg::MODE_ENQ, 2560, -2560, 0);
        send_item(wfs_pkg::MODE_TICK, 0, 0, 0);
        send_item(wfs_pkg::MODE_TICK, 0, 0, 7);
        send_item(wfs_pkg::MODE_TICK, 0, 0, 1023);
        send_item(wfs_pkg::MODE_TICK, 0, 0, 5);
        send_item(wfs_pkg::MODE_TICK, 0, 0, 5);
        // fill past full so enqueues are dropped
        for (int k = 0; k < QDEPTH + 1; k++)
            send_item(wfs_pkg::MODE_ENQ, (k % 2) ? CMAX : CMIN, (k % 3) ? CMIN : CMAX, 0);
        send_item(wfs_pkg::MODE_CLEAR, 0, 0, 0);
    endtask

    task automatic test_overshoot_and_saturation();
        write_reg(wfs_pkg::REG_WALK_SPEED, 16'hFFFF);
        write_reg(wfs_pkg::REG_ARRIVE_TOL, 16'd0);
        send_item(wfs_pkg::MODE_PLACE, CMAX - 10, CMIN + 10, 0);
        send_item(wfs_pkg::MODE_ENQ, CMIN, CMAX, 0);
        send_item(wfs_pkg::MODE_TICK, 0, 0, 1023);
        send_item(wfs_pkg::MODE_TICK, 0, 0, 1023);
        send_item(wfs_pkg::MODE_ENQ, 100, 100, 0);
        send_item(wfs_pkg::MODE_TICK, 0, 0, 1023);
        send_item(wfs_pkg::MODE_CLEAR, 0, 0, 0);
        wait_drained();
    endtask

    task automatic test_random_routes(int n_items);
        logic [wfs_pkg::CFG_W-1:0] v;
        int mode_pick;
        for (int k = 0; k < n_items; k++) begin
            // new register settings every so often, once idle
            if (k % 300 == 0) begin
                wait_drained();
                case ((k / 300) % 4)
                    0: v = 16'd0;
                    1: v = 16'hFFFF;
                    default: v = 16'($urandom_range(0, 4000));
                endcase
                write_reg(wfs_pkg::REG_WALK_SPEED, v);
                write_reg(wfs_pkg::REG_ARRIVE_TOL, ((k / 300) % 3 == 0) ? 16'hFFFF
                                          : 16'($urandom_range(0, 3000)));
            end
            sender_gap();
            mode_pick = $urandom_range(0, 99);
            if (mode_pick < 25)
                send_item(wfs_pkg::MODE_ENQ, rand_coord(), rand_coord(), 0);
            else if (mode_pick < 88)
                send_item(wfs_pkg::MODE_TICK, rand_coord(), rand_coord(),
                          ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                       : $urandom_range(0, 40));
            else if (mode_pick < 92)
                send_item(wfs_pkg::MODE_CLEAR, rand_coord(), rand_coord(),
                          $urandom_range(0, 1023));
            else
                send_item(wfs_pkg::MODE_PLACE, rand_coord(), rand_coord(),
                          $urandom_range(0, 1023));
            if (k == n_items / 2) wait_drained();
        end
    endtask

    initial begin
        n_errors    = 0;
        idle_cycles = 0;
        burst_left  = 0;
        pos_x_m = 0; pos_y_m = 0; vel_x_m = 0; vel_y_m = 0;
        q_head  = 0; q_count = 0;
        speed_m = wfs_pkg::WALK_SPEED_RST;
        tol_m   = wfs_pkg::ARRIVE_TOL_RST;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_mode      = wfs_pkg::MODE_ENQ;
        i_target_x  = '0;
        i_target_y  = '0;
        i_tick_ms   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = wfs_pkg::REG_WALK_SPEED;
        i_cfg_data  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        wait_drained();
        test_overshoot_and_saturation();
        test_random_routes(N_RAND);
        wait_drained();
        repeat (100) @(negedge i_clk);

        if (n_errors == 0 && expected_motion.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
sv/wfs_pkg.sv
sv/wfs_wpt_mem.sv
sv/wfs_isqrt.sv
sv/wfs_div.sv
sv/waypoint_follower_stepper.sv
sim/waypoint_follower_stepper_tb.sv
